### rtl/two_axis_stepper_move_defines.svh
// assertion macros shared by the stepper move rtl
// expects clk and rst_n in the scope of each use
`ifndef TWO_AXIS_STEPPER_MOVE_DEFINES_SVH
`define TWO_AXIS_STEPPER_MOVE_DEFINES_SVH

// same-cycle implication
`define STM_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("stepper move check failed");

// next-cycle implication
`define STM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stepper move check failed");

`endif

### rtl/stm_pkg.sv
// types and constants of the two-axis stepper move block
// no dependencies
package stm_pkg;

  localparam int COORD_W  = 16;
  localparam int TICK_W   = 16;
  localparam int PIX_W    = 8;
  localparam int DELTA_W  = 17;
  localparam int REQ_W    = 3;
  localparam int STAT_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [REQ_W-1:0] REQ_TICK  = 3'd0;
  localparam logic [REQ_W-1:0] REQ_GOTO  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_REL_X = 3'd2;
  localparam logic [REQ_W-1:0] REQ_REL_Y = 3'd3;
  localparam logic [REQ_W-1:0] REQ_ABORT = 3'd4;
  localparam logic [REQ_W-1:0] REQ_HOME  = 3'd5;

  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BUSY  = 2'd2;
  localparam logic [STAT_W-1:0] STAT_THERE = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_SIZE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HALF_STEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_X      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_Y      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_LASER_MOVE = 3'd4;

  localparam logic [PIX_W-1:0]   RST_PIXEL_SIZE = 8'd1;
  localparam logic [TICK_W-1:0]  RST_HALF_STEP  = 16'd1500;
  localparam logic [COORD_W-1:0] RST_MAX        = 16'hffff;

  typedef struct packed {
    logic [PIX_W-1:0]   pixel_size;
    logic [TICK_W-1:0]  half_step_ticks;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] max_y;
    logic               laser_during_move;
  } cfg_t;

  typedef struct packed {
    logic [REQ_W-1:0]          req_type;
    logic [COORD_W-1:0]        target_x;
    logic [COORD_W-1:0]        target_y;
    logic signed [DELTA_W-1:0] delta;
    logic                      breakable;
  } item_t;

  typedef struct packed {
    logic               step_x;
    logic               step_y;
    logic               dir_x;
    logic               dir_y;
    logic               laser_off;
    logic               busy_res;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [STAT_W-1:0]  status;
  } result_t;

  typedef struct packed {
    logic [COORD_W-1:0] cur_x;
    logic [COORD_W-1:0] cur_y;
    logic [COORD_W-1:0] goal_x;
    logic [COORD_W-1:0] goal_y;
    logic [TICK_W-1:0]  tick_count;
    logic [PIX_W-1:0]   pulse_count;
    logic               phase_high;
    logic               moving;
    logic               move_breakable;
    logic               abort_flag;
    logic [1:0]         dir_regs;
    logic               laser_forced;
  } state_t;

endpackage

### rtl/stm_if.sv
// valid/ready channel interfaces for request and result beats
// depends on stm_pkg for field widths
interface stm_in_if;
  logic                                       valid;
  logic                                       ready;
  logic [stm_pkg::REQ_W-1:0]                  req_type;
  logic [stm_pkg::COORD_W-1:0]                target_x;
  logic [stm_pkg::COORD_W-1:0]                target_y;
  logic signed [stm_pkg::DELTA_W-1:0]         delta;
  logic                                       breakable;

  modport source (output valid, req_type, target_x, target_y, delta, breakable,
                  input ready);
  modport sink (input valid, req_type, target_x, target_y, delta, breakable,
                output ready);
endinterface

interface stm_out_if;
  logic                          valid;
  logic                          ready;
  logic                          step_x;
  logic                          step_y;
  logic                          dir_x;
  logic                          dir_y;
  logic                          laser_off;
  logic                          busy_res;
  logic [stm_pkg::COORD_W-1:0]   pos_x;
  logic [stm_pkg::COORD_W-1:0]   pos_y;
  logic [stm_pkg::STAT_W-1:0]    status;

  modport source (output valid, step_x, step_y, dir_x, dir_y, laser_off, busy_res,
                  pos_x, pos_y, status, input ready);
  modport sink (input valid, step_x, step_y, dir_x, dir_y, laser_off, busy_res,
                pos_x, pos_y, status, output ready);
endinterface

### rtl/stm_cfg.sv
// configuration register bank of the stepper move block
// depends on stm_pkg
module stm_cfg (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output stm_pkg::cfg_t                    cfg
);

  stm_pkg::cfg_t cfg_r;
  stm_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_idx)
        stm_pkg::CFG_PIXEL_SIZE: cfg_nxt.pixel_size = cfg_wdata[stm_pkg::PIX_W-1:0];
        stm_pkg::CFG_HALF_STEP:  cfg_nxt.half_step_ticks = cfg_wdata[stm_pkg::TICK_W-1:0];
        stm_pkg::CFG_MAX_X:      cfg_nxt.max_x = cfg_wdata[stm_pkg::COORD_W-1:0];
        stm_pkg::CFG_MAX_Y:      cfg_nxt.max_y = cfg_wdata[stm_pkg::COORD_W-1:0];
        stm_pkg::CFG_LASER_MOVE: cfg_nxt.laser_during_move = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_size        <= stm_pkg::RST_PIXEL_SIZE;
      cfg_r.half_step_ticks   <= stm_pkg::RST_HALF_STEP;
      cfg_r.max_x             <= stm_pkg::RST_MAX;
      cfg_r.max_y             <= stm_pkg::RST_MAX;
      cfg_r.laser_during_move <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/stm_core.sv
// motion state registers and the per-beat update logic
// depends on stm_pkg and two_axis_stepper_move_defines.svh
`include "two_axis_stepper_move_defines.svh"

module stm_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_valid,
  input  stm_pkg::item_t    item,
  input  stm_pkg::cfg_t     cfg,
  output stm_pkg::result_t  res
);

  localparam int CW = stm_pkg::COORD_W;
  localparam int TW = stm_pkg::TICK_W;
  localparam int PW = stm_pkg::PIX_W;
  localparam int DW = stm_pkg::DELTA_W;

  stm_pkg::state_t st_r;
  stm_pkg::state_t st_nxt;
  logic [stm_pkg::STAT_W-1:0] status;

  logic [TW-1:0] half_eff;
  logic [TW-1:0] tick_inc;
  logic [PW-1:0] pix_eff;
  logic [PW-1:0] pulse_inc;
  logic [CW-1:0] unit_x;
  logic [CW-1:0] unit_y;

  logic          rel_axis_y;
  logic [CW-1:0] rel_cur;
  logic [CW-1:0] rel_max;
  logic [DW-1:0] rel_raw;
  logic          rel_neg;
  logic [DW-1:0] rel_mag;
  logic [CW+1:0] rel_sum;
  logic [DW-1:0] rel_dif;
  logic          rel_low;
  logic          rel_high;
  logic [CW-1:0] rel_new;

  logic [CW:0]   home_sum_x;
  logic [CW:0]   home_sum_y;
  logic [CW-1:0] home_x;
  logic [CW-1:0] home_y;

  function automatic stm_pkg::state_t begin_move(stm_pkg::state_t s, logic [CW-1:0] gx,
                                                  logic [CW-1:0] gy, logic brk);
    stm_pkg::state_t r;
    r = s;
    r.goal_x         = gx;
    r.goal_y         = gy;
    r.tick_count     = '0;
    r.pulse_count    = '0;
    r.phase_high     = 1'b0;
    r.moving         = 1'b1;
    r.move_breakable = brk;
    r.abort_flag     = 1'b0;
    return r;
  endfunction

  function automatic stm_pkg::state_t end_move(stm_pkg::state_t s);
    stm_pkg::state_t r;
    r = s;
    r.moving       = 1'b0;
    r.phase_high   = 1'b0;
    r.tick_count   = '0;
    r.pulse_count  = '0;
    r.abort_flag   = 1'b0;
    r.laser_forced = 1'b0;
    return r;
  endfunction

  assign half_eff  = (cfg.half_step_ticks == '0) ? TW'(1) : cfg.half_step_ticks;
  assign pix_eff   = (cfg.pixel_size == '0) ? PW'(1) : cfg.pixel_size;
  assign tick_inc  = st_r.tick_count + TW'(1);
  assign pulse_inc = st_r.pulse_count + PW'(1);

  assign unit_x = (st_r.cur_x == st_r.goal_x) ? st_r.cur_x :
                  (st_r.goal_x < st_r.cur_x) ? st_r.cur_x - CW'(1) : st_r.cur_x + CW'(1);
  assign unit_y = (st_r.cur_y == st_r.goal_y) ? st_r.cur_y :
                  (st_r.goal_y < st_r.cur_y) ? st_r.cur_y - CW'(1) : st_r.cur_y + CW'(1);

  // relative single-axis move
  assign rel_axis_y = (item.req_type == stm_pkg::REQ_REL_Y);
  assign rel_cur    = rel_axis_y ? st_r.cur_y : st_r.cur_x;
  assign rel_max    = rel_axis_y ? cfg.max_y : cfg.max_x;
  assign rel_raw    = item.delta;
  assign rel_neg    = rel_raw[DW-1];
  assign rel_mag    = rel_neg ? (~rel_raw + DW'(1)) : rel_raw;
  assign rel_sum    = {2'b00, rel_cur} + {1'b0, rel_mag};
  assign rel_dif    = {1'b0, rel_cur} - rel_mag;
  assign rel_low    = ({1'b0, rel_cur} < rel_mag);
  assign rel_high   = (rel_sum > {2'b00, rel_max});
  assign rel_new    = rel_neg ? rel_dif[CW-1:0] : rel_sum[CW-1:0];

  // home pre-offset, saturating
  assign home_sum_x = {1'b0, st_r.cur_x} + {4'b0000, cfg.max_x[CW-1:3]};
  assign home_sum_y = {1'b0, st_r.cur_y} + {3'b000, cfg.max_y[CW-1:2]};
  assign home_x     = home_sum_x[CW] ? {CW{1'b1}} : home_sum_x[CW-1:0];
  assign home_y     = home_sum_y[CW] ? {CW{1'b1}} : home_sum_y[CW-1:0];

  always_comb begin
    st_nxt = st_r;
    status = stm_pkg::STAT_OK;
    unique case (item.req_type)
      stm_pkg::REQ_TICK: begin
        if (st_r.moving) begin
          if (tick_inc < half_eff) begin
            st_nxt.tick_count = tick_inc;
          end else if (!st_r.phase_high) begin
            st_nxt.tick_count = '0;
            st_nxt.phase_high = 1'b1;
          end else begin
            st_nxt.tick_count = '0;
            st_nxt.phase_high = 1'b0;
            if (pulse_inc < pix_eff) begin
              st_nxt.pulse_count = pulse_inc;
            end else begin
              st_nxt.pulse_count = '0;
              st_nxt.cur_x = unit_x;
              st_nxt.cur_y = unit_y;
              if ((unit_x == st_r.goal_x && unit_y == st_r.goal_y) ||
                  (st_r.abort_flag && st_r.move_breakable)) begin
                st_nxt = end_move(st_nxt);
              end
            end
          end
        end
      end
      stm_pkg::REQ_ABORT: begin
        if (st_r.moving) begin
          st_nxt.abort_flag = 1'b1;
        end
      end
      stm_pkg::REQ_GOTO: begin
        if (st_r.moving) begin
          status = stm_pkg::STAT_BUSY;
        end else if (item.target_x == st_r.cur_x && item.target_y == st_r.cur_y) begin
          status = stm_pkg::STAT_THERE;
        end else if (item.target_x > cfg.max_x || item.target_y > cfg.max_y) begin
          status = stm_pkg::STAT_RANGE;
        end else begin
          if (!cfg.laser_during_move) begin
            st_nxt.laser_forced = 1'b1;
          end
          st_nxt.dir_regs = {item.target_y < st_r.cur_y, item.target_x < st_r.cur_x};
          st_nxt = begin_move(st_nxt, item.target_x, item.target_y, item.breakable);
        end
      end
      stm_pkg::REQ_REL_X, stm_pkg::REQ_REL_Y: begin
        if (st_r.moving) begin
          status = stm_pkg::STAT_BUSY;
        end else if (rel_mag != '0) begin
          if ((rel_neg && rel_low) || (!rel_neg && rel_high)) begin
            status = stm_pkg::STAT_RANGE;
          end else begin
            if (rel_axis_y) begin
              st_nxt.dir_regs[1] = rel_neg;
              st_nxt = begin_move(st_nxt, st_r.cur_x, rel_new, 1'b0);
            end else begin
              st_nxt.dir_regs[0] = rel_neg;
              st_nxt = begin_move(st_nxt, rel_new, st_r.cur_y, 1'b0);
            end
          end
        end
      end
      stm_pkg::REQ_HOME: begin
        if (st_r.moving) begin
          status = stm_pkg::STAT_BUSY;
        end else begin
          st_nxt.cur_x = home_x;
          st_nxt.cur_y = home_y;
          if (home_x != '0 || home_y != '0) begin
            st_nxt.laser_forced = 1'b1;
            st_nxt.dir_regs = {home_y != '0, home_x != '0};
            st_nxt = begin_move(st_nxt, '0, '0, 1'b0);
          end
        end
      end
      default: st_nxt = st_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (item_valid) begin
      st_r <= st_nxt;
    end
  end

  assign res.step_x    = st_nxt.moving && st_nxt.phase_high && (st_nxt.cur_x != st_nxt.goal_x);
  assign res.step_y    = st_nxt.moving && st_nxt.phase_high && (st_nxt.cur_y != st_nxt.goal_y);
  assign res.dir_x     = st_nxt.dir_regs[0];
  assign res.dir_y     = st_nxt.dir_regs[1];
  assign res.laser_off = st_nxt.laser_forced;
  assign res.busy_res  = st_nxt.moving;
  assign res.pos_x     = st_nxt.cur_x;
  assign res.pos_y     = st_nxt.cur_y;
  assign res.status    = status;

  `STM_ASSERT_IMPL(a_idle_counters_clear, !st_r.moving,
    !st_r.phase_high && st_r.tick_count == '0 && st_r.pulse_count == '0)
  `STM_ASSERT_NEXT(a_busy_goto_keeps_goal,
    item_valid && st_r.moving && item.req_type == stm_pkg::REQ_GOTO,
    st_r.goal_x == $past(st_r.goal_x) && st_r.goal_y == $past(st_r.goal_y))
  `STM_ASSERT_NEXT(a_no_beat_holds_position, !item_valid,
    st_r.cur_x == $past(st_r.cur_x) && st_r.cur_y == $past(st_r.cur_y))

endmodule

### rtl/two_axis_stepper_move.sv
// two-axis step/direction move controller
// usage: requests enter on in_ch, one result per request leaves on out_ch.
// request 0 is a timing tick; goto, relative x/y, abort and home are commands.
// registers are written on cfg_we with cfg_idx and cfg_wdata; the user must
// write them only while idle, which the block itself leaves unenforced.
// an accepted beat enters the input register, its result the result register.
// throughput: one beat per cycle unless out_ch stalls, set by the single state
// update between the input register and the result register.
// reset (rst_n low, synchronous): both pipeline registers empty, position,
// goal and timing counters zero, registers at their reset values.
// stall: while a result waits on out_ch.ready low, the result register holds;
// one more beat enters the input register, after which in_ch.ready drops.
// depends on stm_pkg, stm_if, stm_cfg, stm_core and the defines header
`include "two_axis_stepper_move_defines.svh"

module two_axis_stepper_move (
  input  logic                             clk,
  input  logic                             rst_n,
  stm_in_if.sink                           in_ch,
  stm_out_if.source                        out_ch,
  input  logic                             cfg_we,
  input  logic [stm_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [stm_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  stm_pkg::cfg_t    cfg;
  stm_pkg::item_t   in_item;
  stm_pkg::item_t   s1_item_r;
  logic             s1_valid_r;
  logic             s1_go;
  stm_pkg::result_t core_res;
  stm_pkg::result_t out_res_r;
  logic             out_valid_r;
  logic             in_ready;

  stm_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  assign in_item.req_type  = in_ch.req_type;
  assign in_item.target_x  = in_ch.target_x;
  assign in_item.target_y  = in_ch.target_y;
  assign in_item.delta     = in_ch.delta;
  assign in_item.breakable = in_ch.breakable;

  assign s1_go    = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ready = !s1_valid_r || s1_go;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_ch.valid) begin
      s1_item_r <= in_item;
    end
  end

  stm_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (s1_go),
    .item       (s1_item_r),
    .cfg        (cfg),
    .res        (core_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_res_r <= core_res;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.step_x    = out_res_r.step_x;
  assign out_ch.step_y    = out_res_r.step_y;
  assign out_ch.dir_x     = out_res_r.dir_x;
  assign out_ch.dir_y     = out_res_r.dir_y;
  assign out_ch.laser_off = out_res_r.laser_off;
  assign out_ch.busy_res  = out_res_r.busy_res;
  assign out_ch.pos_x     = out_res_r.pos_x;
  assign out_ch.pos_y     = out_res_r.pos_y;
  assign out_ch.status    = out_res_r.status;

  `STM_ASSERT_IMPL(a_full_stall_blocks_input,
    s1_valid_r && out_valid_r && !out_ch.ready, !in_ch.ready)
  `STM_ASSERT_NEXT(a_stage_beat_reaches_output, s1_go, out_valid_r)

endmodule

### sim/tb.sv
// testbench for two_axis_stepper_move: directed and random request beats, with
// results checked against an in-bench model of the step, direction and position logic
// depends on stm_pkg, two_axis_stepper_move and the stm_in_if / stm_out_if interfaces
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import stm_pkg::*;

  localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
  localparam int TICK_CHUNK = 16;
  localparam int STALL_LIMIT = 2000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  stm_in_if in_ch();
  stm_out_if out_ch();

  two_axis_stepper_move DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_idx(cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  cfg_t regs;
  state_t mv;
  item_t req_queue[$];
  result_t pin_queue[$];
  item_t beat_now;
  result_t seen, want;
  bit full_rate = 1'b0;
  int burst_left, gap_left, stall_cycles;
  int queued, accepted, results_seen, faults, setups, moves_done, moves_cut;
  logic [15:0] rx_pat;
  int rx_left;

  function automatic void launch_move(input logic [COORD_W-1:0] gx, gy, input logic brk);
    mv.goal_x = gx;
    mv.goal_y = gy;
    mv.tick_count = '0;
    mv.pulse_count = '0;
    mv.phase_high = 1'b0;
    mv.moving = 1'b1;
    mv.move_breakable = brk;
    mv.abort_flag = 1'b0;
  endfunction

  function automatic void park_axes();
    mv.moving = 1'b0;
    mv.phase_high = 1'b0;
    mv.tick_count = '0;
    mv.pulse_count = '0;
    mv.abort_flag = 1'b0;
    mv.laser_forced = 1'b0;
  endfunction

  function automatic result_t advance_axes(input item_t b);
    logic [TICK_W-1:0] half_lim;
    logic [PIX_W-1:0] pix_lim;
    logic [STAT_W-1:0] st;
    logic [DELTA_W-1:0] mag;
    logic [COORD_W:0] wide;
    logic [COORD_W+1:0] sum;
    logic neg, on_y;
    logic [COORD_W-1:0] here, lim, dest;
    result_t r;
    half_lim = (regs.half_step_ticks == '0) ? TICK_W'(1) : regs.half_step_ticks;
    pix_lim = (regs.pixel_size == '0) ? PIX_W'(1) : regs.pixel_size;
    st = STAT_OK;
    dest = '0;
    case (b.req_type)
      REQ_TICK: begin
        if (mv.moving) begin
          mv.tick_count = mv.tick_count + 1'b1;
          if (mv.tick_count >= half_lim) begin
            mv.tick_count = '0;
            if (!mv.phase_high) begin
              mv.phase_high = 1'b1;
            end else begin
              mv.phase_high = 1'b0;
              mv.pulse_count = mv.pulse_count + 1'b1;
              if (mv.pulse_count >= pix_lim) begin
                mv.pulse_count = '0;
                if (mv.cur_x != mv.goal_x)
                  mv.cur_x = (mv.goal_x < mv.cur_x) ? mv.cur_x - 1'b1 : mv.cur_x + 1'b1;
                if (mv.cur_y != mv.goal_y)
                  mv.cur_y = (mv.goal_y < mv.cur_y) ? mv.cur_y - 1'b1 : mv.cur_y + 1'b1;
                if (mv.cur_x == mv.goal_x && mv.cur_y == mv.goal_y) begin
                  moves_done++;
                  park_axes();
                end else if (mv.abort_flag && mv.move_breakable) begin
                  moves_cut++;
                  park_axes();
                end
              end
            end
          end
        end
      end
      REQ_ABORT: begin
        if (mv.moving) mv.abort_flag = 1'b1;
      end
      REQ_GOTO: begin
        if (mv.moving) begin
          st = STAT_BUSY;
        end else if (b.target_x == mv.cur_x && b.target_y == mv.cur_y) begin
          st = STAT_THERE;
        end else if (b.target_x > regs.max_x || b.target_y > regs.max_y) begin
          st = STAT_RANGE;
        end else begin
          if (!regs.laser_during_move) mv.laser_forced = 1'b1;
          mv.dir_regs = {b.target_y < mv.cur_y, b.target_x < mv.cur_x};
          launch_move(b.target_x, b.target_y, b.breakable);
        end
      end
      REQ_REL_X, REQ_REL_Y: begin
        if (mv.moving) begin
          st = STAT_BUSY;
        end else begin
          on_y = (b.req_type == REQ_REL_Y);
          here = on_y ? mv.cur_y : mv.cur_x;
          lim = on_y ? regs.max_y : regs.max_x;
          neg = b.delta[DELTA_W-1];
          mag = neg ? DELTA_W'(-b.delta) : DELTA_W'(b.delta);
          if (mag != '0) begin
            if (neg) begin
              if ({1'b0, here} < mag) begin
                st = STAT_RANGE;
              end else begin
                dest = here - mag[COORD_W-1:0];
                mv.dir_regs[on_y] = 1'b1;
              end
            end else begin
              sum = {2'b00, here} + {1'b0, mag};
              if (sum > {2'b00, lim}) begin
                st = STAT_RANGE;
              end else begin
                dest = sum[COORD_W-1:0];
                mv.dir_regs[on_y] = 1'b0;
              end
            end
            if (st == STAT_OK) begin
              if (on_y) launch_move(mv.cur_x, dest, 1'b0);
              else launch_move(dest, mv.cur_y, 1'b0);
            end
          end
        end
      end
      REQ_HOME: begin
        if (mv.moving) begin
          st = STAT_BUSY;
        end else begin
          wide = {1'b0, mv.cur_x} + {1'b0, regs.max_x >> 3};
          mv.cur_x = wide[COORD_W] ? '1 : wide[COORD_W-1:0];
          wide = {1'b0, mv.cur_y} + {1'b0, regs.max_y >> 2};
          mv.cur_y = wide[COORD_W] ? '1 : wide[COORD_W-1:0];
          if (mv.cur_x != '0 || mv.cur_y != '0) begin
            mv.laser_forced = 1'b1;
            mv.dir_regs = {mv.cur_y != '0, mv.cur_x != '0};
            launch_move('0, '0, 1'b0);
          end
        end
      end
      default: begin
      end
    endcase
    r.step_x = mv.moving && mv.phase_high && (mv.cur_x != mv.goal_x);
    r.step_y = mv.moving && mv.phase_high && (mv.cur_y != mv.goal_y);
    r.dir_x = mv.dir_regs[0];
    r.dir_y = mv.dir_regs[1];
    r.laser_off = mv.laser_forced;
    r.busy_res = mv.moving;
    r.pos_x = mv.cur_x;
    r.pos_y = mv.cur_y;
    r.status = st;
    return r;
  endfunction

  function automatic string show(input result_t r);
    return $sformatf("step %b%b dir %b%b laser_off %b busy %b pos (%0d,%0d) status %0d",
                     r.step_x, r.step_y, r.dir_x, r.dir_y, r.laser_off, r.busy_res,
                     r.pos_x, r.pos_y, r.status);
  endfunction

  // request driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        pin_queue.push_back(advance_axes(beat_now));
        accepted++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left != 0 && !full_rate) begin
          in_ch.valid <= 1'b0;
          gap_left <= gap_left - 1;
        end else if (req_queue.size() != 0) begin
          beat_now = req_queue.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.req_type <= beat_now.req_type;
          in_ch.target_x <= beat_now.target_x;
          in_ch.target_y <= beat_now.target_y;
          in_ch.delta <= beat_now.delta;
          in_ch.breakable <= beat_now.breakable;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_pat <= 16'hffff;
      rx_left <= 0;
    end else begin
      if (rx_left == 0) begin
        rx_pat <= ($urandom_range(0, 3) == 0) ? 16'hffff : (16'($urandom) | 16'h0001);
        rx_left <= 64;
      end else begin
        rx_pat <= {rx_pat[0], rx_pat[15:1]};
        rx_left <= rx_left - 1;
      end
      out_ch.ready <= full_rate || rx_pat[0];
      if (out_ch.valid && out_ch.ready) begin
        seen.step_x = out_ch.step_x;
        seen.step_y = out_ch.step_y;
        seen.dir_x = out_ch.dir_x;
        seen.dir_y = out_ch.dir_y;
        seen.laser_off = out_ch.laser_off;
        seen.busy_res = out_ch.busy_res;
        seen.pos_x = out_ch.pos_x;
        seen.pos_y = out_ch.pos_y;
        seen.status = out_ch.status;
        results_seen++;
        if (pin_queue.size() == 0) begin
          faults++;
          if (faults <= 10) $display("result beat with nothing expected: %s", show(seen));
        end else begin
          want = pin_queue.pop_front();
          if (seen !== want) begin
            faults++;
            if (faults <= 10) begin
              $display("mismatch at result %0d", results_seen);
              $display("  expected %s", show(want));
              $display("  actual   %s", show(seen));
            end
          end
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (req_queue.size() == 0 && pin_queue.size() == 0 && !in_ch.valid)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  task automatic push(input logic [REQ_W-1:0] op, input logic [COORD_W-1:0] tx, ty,
                      input logic [DELTA_W-1:0] d, input logic brk);
    item_t it;
    it.req_type = op;
    it.target_x = tx;
    it.target_y = ty;
    it.delta = d;
    it.breakable = brk;
    req_queue.push_back(it);
    queued++;
  endtask

  task automatic push_tick(input int n);
    for (int i = 0; i < n; i++)
      push(REQ_TICK, 16'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
  endtask

  task automatic drain();
    do @(negedge clk);
    while (req_queue.size() != 0 || in_ch.valid || pin_queue.size() != 0);
    repeat (3) @(negedge clk);
  endtask

  task automatic run_out();
    drain();
    while (mv.moving) begin
      push_tick(TICK_CHUNK);
      drain();
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_PIXEL_SIZE: regs.pixel_size = val[PIX_W-1:0];
      CFG_HALF_STEP:  regs.half_step_ticks = val[TICK_W-1:0];
      CFG_MAX_X:      regs.max_x = val[COORD_W-1:0];
      CFG_MAX_Y:      regs.max_y = val[COORD_W-1:0];
      CFG_LASER_MOVE: regs.laser_during_move = val[0];
      default: begin
      end
    endcase
    @(negedge clk);
  endtask

  task automatic set_regs(input int pix, half, mx, my, las);
    drain();
    write_reg(CFG_PIXEL_SIZE, CFG_DATA_W'(pix));
    write_reg(CFG_HALF_STEP, CFG_DATA_W'(half));
    write_reg(CFG_MAX_X, CFG_DATA_W'(mx));
    write_reg(CFG_MAX_Y, CFG_DATA_W'(my));
    write_reg(CFG_LASER_MOVE, CFG_DATA_W'(las));
    setups++;
  endtask

  initial begin
    int k, span, d, stop_at;
    logic on_y;
    in_ch.valid = 1'b0;
    in_ch.req_type = REQ_TICK;
    in_ch.target_x = '0;
    in_ch.target_y = '0;
    in_ch.delta = '0;
    in_ch.breakable = 1'b0;
    out_ch.ready = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = CFG_PIXEL_SIZE;
    cfg_wdata = '0;
    regs.pixel_size = RST_PIXEL_SIZE;
    regs.half_step_ticks = RST_HALF_STEP;
    regs.max_x = RST_MAX;
    regs.max_y = RST_MAX;
    regs.laser_during_move = 1'b0;
    mv = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset settings, commands that never start a move
    push(REQ_SPARE_LO, 16'hffff, 16'h0000, 17'h1ffff, 1'b1);
    push(REQ_SPARE_HI, 16'h0000, 16'hffff, 17'h00000, 1'b0);
    push(REQ_ABORT, 16'($urandom), 16'($urandom), 17'($urandom), 1'b1);
    push(REQ_GOTO, 16'd0, 16'd0, 17'($urandom), 1'b1);
    push(REQ_REL_X, 16'($urandom), 16'($urandom), 17'd0, 1'b0);
    push_tick(4);

    set_regs(2, 1, 20, 12, 0);
    push(REQ_GOTO, 16'd21, 16'd3, 17'd0, 1'b0);
    push(REQ_GOTO, 16'd3, 16'd13, 17'd0, 1'b0);
    push(REQ_REL_X, 16'd0, 16'd0, 17'h10000, 1'b0);
    push(REQ_REL_Y, 16'd0, 16'd0, 17'h0ffff, 1'b0);
    push(REQ_HOME, 16'($urandom), 16'($urandom), 17'($urandom), 1'b1);
    push_tick(3);
    push(REQ_GOTO, 16'd5, 16'd5, 17'd0, 1'b1);
    push(REQ_REL_X, 16'd0, 16'd0, 17'd1, 1'b0);
    push(REQ_HOME, 16'd0, 16'd0, 17'd0, 1'b0);
    push(REQ_ABORT, 16'd0, 16'd0, 17'd0, 1'b1);
    run_out();
    push(REQ_GOTO, 16'd20, 16'd12, 17'd0, 1'b1);
    push_tick(20);
    push(REQ_ABORT, 16'd0, 16'd0, 17'd0, 1'b0);
    run_out();
    push(REQ_REL_X, 16'd0, 16'd0, 17'd3, 1'b1);
    push_tick(5);
    push(REQ_ABORT, 16'd0, 16'd0, 17'd0, 1'b1);
    run_out();
    push(REQ_REL_Y, 16'd0, 16'd0, 17'h1ffff, 1'b0);
    run_out();
    push(REQ_GOTO, 16'd20, 16'd12, 17'd0, 1'b0);
    run_out();
    write_reg(CFG_LASER_MOVE, CFG_DATA_W'(1));
    push(REQ_GOTO, 16'd0, 16'd0, 17'd0, 1'b1);
    run_out();

    // slow pulse, then the timing registers lowered mid move
    set_regs(5, 40, 20, 12, 0);
    push(REQ_GOTO, 16'd3, 16'd3, 17'd0, 1'b0);
    push_tick(100);
    drain();
    write_reg(CFG_HALF_STEP, CFG_DATA_W'(1));
    push_tick(3);
    drain();
    write_reg(CFG_PIXEL_SIZE, CFG_DATA_W'(1));
    run_out();

    set_regs(255, 65535, 65535, 65535, 1);
    push(REQ_REL_Y, 16'd0, 16'd0, 17'd1, 1'b0);
    push_tick(20);
    drain();
    write_reg(CFG_HALF_STEP, CFG_DATA_W'(0));
    push_tick(20);
    drain();
    write_reg(CFG_PIXEL_SIZE, CFG_DATA_W'(0));
    run_out();
    push(REQ_REL_X, 16'd0, 16'd0, 17'd1, 1'b0);
    run_out();

    set_regs(1, 1, 0, 0, 0);
    push(REQ_GOTO, 16'd1, 16'd0, 17'd0, 1'b0);
    push(REQ_HOME, 16'd0, 16'd0, 17'd0, 1'b0);
    run_out();
    push(REQ_HOME, 16'd0, 16'd0, 17'd0, 1'b0);
    push(REQ_GOTO, 16'hffff, 16'hffff, 17'd0, 1'b1);
    push(REQ_GOTO, 16'd0, 16'd0, 17'd0, 1'b1);

    // both ends of the coordinate range rejected, then a short home at full rate
    set_regs(1, 1, 65534, 65535, 0);
    full_rate = 1'b1;
    push(REQ_REL_X, 16'd0, 16'd0, 17'h0ffff, 1'b0);
    push(REQ_GOTO, 16'hffff, 16'd0, 17'd0, 1'b0);
    push(REQ_REL_Y, 16'd0, 16'd0, 17'h10000, 1'b0);
    run_out();
    write_reg(CFG_MAX_X, CFG_DATA_W'(8));
    write_reg(CFG_MAX_Y, CFG_DATA_W'(4));
    push(REQ_HOME, 16'd0, 16'd0, 17'd0, 1'b0);
    run_out();
    full_rate = 1'b0;

    for (int p = 0; p < 4; p++) begin
      set_regs($urandom_range(0, 3), $urandom_range(0, 3),
               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24),
               ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 24),
               $urandom_range(0, 1));
      stop_at = queued + 40;
      while (queued < stop_at) begin
        k = $urandom_range(0, 99);
        if (k < 35) begin
          push(REQ_GOTO,
               ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, regs.max_x)),
               ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, regs.max_y)),
               17'($urandom), 1'($urandom));
          push_tick($urandom_range(0, 40));
          if ($urandom_range(0, 3) == 0) begin
            push(REQ_ABORT, 16'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
            push_tick($urandom_range(0, 30));
          end
        end else if (k < 60) begin
          on_y = 1'($urandom);
          span = on_y ? regs.max_y : regs.max_x;
          d = int'($urandom_range(0, 2 * span + 2)) - (span + 1);
          push(on_y ? REQ_REL_Y : REQ_REL_X, 16'($urandom), 16'($urandom),
               ($urandom_range(0, 6) == 0) ? 17'($urandom) : 17'(d), 1'($urandom));
          push_tick($urandom_range(0, 40));
        end else if (k < 68) begin
          push(REQ_HOME, 16'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
          push_tick($urandom_range(0, 40));
        end else if (k < 76) begin
          push(REQ_ABORT, 16'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
        end else if (k < 80) begin
          push(($urandom_range(0, 1) == 0) ? REQ_SPARE_LO : REQ_SPARE_HI,
               16'($urandom), 16'($urandom), 17'($urandom), 1'($urandom));
        end else begin
          push_tick($urandom_range(1, 50));
        end
        if ($urandom_range(0, 4) == 0) run_out();
      end
      run_out();
    end

    drain();
    repeat (8) @(negedge clk);
    $display("covered %0d request beats and %0d result beats over %0d register setups",
             accepted, results_seen, setups);
    $display("moves run to the goal: %0d, moves cut short by abort: %0d", moves_done, moves_cut);
    if (faults == 0 && pin_queue.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches in total", faults);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

### sim.f
+incdir+rtl
rtl/stm_pkg.sv
rtl/stm_if.sv
rtl/stm_cfg.sv
rtl/stm_core.sv
rtl/two_axis_stepper_move.sv
sim/tb.sv
